FILE: rtl/pnew_pkg.sv
package pnew_pkg;

  // field widths
  localparam int CH_W     = 8;
  localparam int PIX_W    = 3 * CH_W;
  localparam int WT_W     = 24;
  localparam int IW_W     = 11;
  localparam int BETA_W   = 32;
  localparam int GAMMA_W  = 8;
  localparam int CFG_IX_W = 2;
  localparam int CFG_D_W  = 32;

  // register indexes
  localparam logic [CFG_IX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IX_W-1:0] CFG_BETA_SCALE  = 2'd1;
  localparam logic [CFG_IX_W-1:0] CFG_GAMMA_GAIN  = 2'd2;

  // register reset values
  localparam logic [IW_W-1:0]    IMAGE_WIDTH_RESET = 11'd1024;
  localparam logic [GAMMA_W-1:0] GAMMA_GAIN_RESET  = 8'd50;

  // arithmetic constants
  localparam int          MAX_WIDTH_DEF = 1024;
  localparam logic [15:0] DIAG_SCALE    = 16'd46341;
  localparam int          TAYLOR_TERMS  = 24;
  localparam logic [43:0] EXP_LIMIT     = 44'd12 << 16;
  localparam logic [33:0] Q32_ONE       = 34'h1_0000_0000;
  localparam logic [16:0] Q16_ONE       = 17'h1_0000;

endpackage

FILE: rtl/pnew_ram.sv
module pnew_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pixel_neighbor_edge_weights_top.sv
// Edge weights for a raster RGB pixel stream, one line store in a single-port-read
// RAM. Each pixel word yields one result word of four Q8.16 weights
// gamma*exp(-beta*d2) to the left, up-left, up and up-right neighbours (diagonals
// scaled by 1/sqrt2, weights outside the image are 0). One pixel is worked at a
// time through a shared multiplier and a radix-2 divider; a new pixel is taken
// only in idle. Per neighbour inside the image a 24-term Taylor series runs (the
// bit-serial divide by the term index dominates), then a power step, a multiply
// by exp(-1), per whole unit of the exp argument; a neighbour whose argument
// reaches 12 skips the series and the power steps. After reset the block
// computes exp(-1) before it takes its first pixel; configuration writes are
// taken at any time but should only be issued while idle.
module pixel_neighbor_edge_weights_top
  import pnew_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CH_W-1:0]     in_red,
  input  logic [CH_W-1:0]     in_green,
  input  logic [CH_W-1:0]     in_blue,
  input  logic                in_frame_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WT_W-1:0]     out_left_weight,
  output logic [WT_W-1:0]     out_upleft_weight,
  output logic [WT_W-1:0]     out_up_weight,
  output logic [WT_W-1:0]     out_upright_weight,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = (WW > IW_W) ? WW : IW_W;

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_RD1, S_RD2, S_NEXT, S_D2, S_BETA, S_CHK, S_TM, S_DIV,
    S_ACC, S_PWLO, S_PWHI, S_RND, S_GAM, S_DIAG, S_STORE, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [IW_W-1:0]    image_width_r;
  logic [BETA_W-1:0]  beta_r;
  logic [GAMMA_W-1:0] gamma_r;

  // stream state
  logic [PIX_W-1:0] left_pixel_r;
  logic [PIX_W-1:0] up_hold_r;
  logic [CW-1:0]    col_r;
  logic             first_r;

  // per pixel work
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] nb_r [4];
  logic [3:0]       mask_r;
  logic [CW-1:0]    j_r;
  logic [1:0]       sel_r;
  logic [WT_W-1:0]  res_r [4];

  // exp datapath
  logic [17:0] d2_r;
  logic [43:0] a_r;
  logic [3:0]  n_r;
  logic [16:0] r_r;
  logic [33:0] term_r;
  logic [33:0] sum_r;
  logic [4:0]  k_r;
  logic [33:0] div_q_r;
  logic [4:0]  rem_r;
  logic [5:0]  cnt_r;
  logic [33:0] y_r;
  logic [65:0] acc_r;
  logic [16:0] e_r;
  logic [24:0] wt_r;
  logic [31:0] e1_r;
  logic        boot_r;

  // output register
  logic            out_valid_r;
  logic [WT_W-1:0] out_w_r [4];

  logic            ram_we;
  logic [CW-1:0]   ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  // effective width, clamped to 1..MAX_WIDTH
  logic [EW-1:0] iw_ext;
  logic [WW-1:0] w_eff;
  always_comb begin
    iw_ext = EW'(image_width_r);
    if (iw_ext == '0) begin
      w_eff = WW'(1);
    end else if (iw_ext > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = iw_ext[WW-1:0];
    end
  end

  // column and first-row flag for an incoming word
  logic          in_acc;
  logic [CW-1:0] col_c;
  logic          first_c;
  logic [WW-1:0] jp1_c;
  always_comb begin
    col_c   = in_frame_start ? '0 : col_r;
    first_c = in_frame_start ? 1'b1 : first_r;
    if ({1'b0, col_c} >= w_eff) begin
      col_c   = '0;
      first_c = 1'b0;
    end
    jp1_c = {1'b0, col_c} + WW'(1);
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // column after the current pixel
  logic [WW-1:0] jn_c;
  assign jn_c = {1'b0, j_r} + WW'(1);

  // squared rgb distance to the selected neighbour
  logic [17:0] d2_c;
  always_comb begin
    logic signed [CH_W:0]     dd;
    logic signed [2*CH_W+1:0] sq;
    d2_c = '0;
    for (int c = 0; c < 3; c++) begin
      dd   = $signed({1'b0, pix_r[c*CH_W +: CH_W]}) -
             $signed({1'b0, nb_r[sel_r][c*CH_W +: CH_W]});
      sq   = dd * dd;
      d2_c = d2_c + unsigned'(sq);
    end
  end

  // shared multiplier
  logic [33:0] mul_a;
  logic [17:0] mul_b;
  logic [51:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_BETA: begin mul_a = 34'(beta_r);  mul_b = d2_r;                 end
      S_TM:   begin mul_a = term_r;       mul_b = 18'(r_r);             end
      S_PWLO: begin mul_a = y_r;          mul_b = 18'(e1_r[15:0]);      end
      S_PWHI: begin mul_a = y_r;          mul_b = 18'(e1_r[31:16]);     end
      S_GAM:  begin mul_a = 34'(gamma_r); mul_b = 18'(e_r);             end
      S_DIAG: begin mul_a = 34'(wt_r);    mul_b = 18'(DIAG_SCALE);      end
      default: begin mul_a = '0;          mul_b = '0;                   end
    endcase
    mul_p = 52'(mul_a) * 52'(mul_b);
  end

  // divider step and series accumulate
  logic [5:0]  rem_s;
  logic        div_ge;
  logic [33:0] sum_new;
  assign rem_s   = {rem_r, div_q_r[33]};
  assign div_ge  = rem_s >= {1'b0, k_r};
  assign sum_new = k_r[0] ? (sum_r - div_q_r) : (sum_r + div_q_r);

  // power step accumulate
  logic [65:0] pw_sum;
  assign pw_sum = acc_r + (66'(mul_p) << 16);

  // line store access
  always_comb begin
    ram_we    = (state_r == S_RD2);
    ram_raddr = (state_r == S_RD1) ? CW'(jn_c) : col_c;
  end

  pnew_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (j_r),
    .wdata (pix_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RESET;
      beta_r        <= '0;
      gamma_r       <= GAMMA_GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH: image_width_r <= cfg_data[IW_W-1:0];
        CFG_BETA_SCALE:  beta_r        <= cfg_data[BETA_W-1:0];
        CFG_GAMMA_GAIN:  gamma_r       <= cfg_data[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_BOOT;
      left_pixel_r <= '0;
      up_hold_r    <= '0;
      col_r        <= '0;
      first_r      <= 1'b1;
      out_valid_r  <= 1'b0;
      boot_r       <= 1'b1;
      sel_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // exp(-1) for the whole-unit steps
        S_BOOT: begin
          r_r     <= Q16_ONE;
          term_r  <= Q32_ONE;
          sum_r   <= Q32_ONE;
          k_r     <= 5'd1;
          boot_r  <= 1'b1;
          state_r <= S_TM;
        end
        S_IDLE: begin
          if (in_acc) begin
            pix_r     <= {in_blue, in_green, in_red};
            j_r       <= col_c;
            first_r   <= first_c;
            mask_r[0] <= col_c != '0;
            mask_r[1] <= (col_c != '0) && !first_c;
            mask_r[2] <= !first_c;
            mask_r[3] <= (jp1_c < w_eff) && !first_c;
            nb_r[0]   <= left_pixel_r;
            nb_r[1]   <= up_hold_r;
            state_r   <= S_RD1;
          end
        end
        S_RD1: begin
          nb_r[2] <= ram_rdata;
          state_r <= S_RD2;
        end
        // store write-back and stream state update
        S_RD2: begin
          nb_r[3]      <= ram_rdata;
          left_pixel_r <= pix_r;
          up_hold_r    <= nb_r[2];
          if (jn_c >= w_eff) begin
            col_r   <= '0;
            first_r <= 1'b0;
          end else begin
            col_r <= CW'(jn_c);
          end
          sel_r   <= '0;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (mask_r[sel_r]) begin
            state_r <= S_D2;
          end else begin
            res_r[sel_r] <= '0;
            if (sel_r == 2'd3) begin
              state_r <= S_OUT;
            end else begin
              sel_r <= sel_r + 2'd1;
            end
          end
        end
        S_D2: begin
          d2_r    <= d2_c;
          state_r <= S_BETA;
        end
        S_BETA: begin
          a_r     <= mul_p[51:8];
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (a_r >= EXP_LIMIT) begin
            e_r     <= '0;
            state_r <= S_GAM;
          end else begin
            n_r     <= a_r[19:16];
            r_r     <= {1'b0, a_r[15:0]};
            term_r  <= Q32_ONE;
            sum_r   <= Q32_ONE;
            k_r     <= 5'd1;
            state_r <= S_TM;
          end
        end
        // taylor term: multiply, then divide by k
        S_TM: begin
          div_q_r <= mul_p[49:16];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r   <= div_ge ? 5'(rem_s - {1'b0, k_r}) : rem_s[4:0];
          div_q_r <= {div_q_r[32:0], div_ge};
          cnt_r   <= cnt_r + 6'd1;
          if (cnt_r == 6'd33) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          term_r <= div_q_r;
          sum_r  <= sum_new;
          if (k_r == 5'(TAYLOR_TERMS)) begin
            if (boot_r) begin
              e1_r    <= sum_new[31:0];
              boot_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              y_r     <= sum_new;
              state_r <= (n_r == '0) ? S_RND : S_PWLO;
            end
          end else begin
            k_r     <= k_r + 5'd1;
            state_r <= S_TM;
          end
        end
        // y = y * exp(-1), two partial products
        S_PWLO: begin
          acc_r   <= 66'(mul_p);
          state_r <= S_PWHI;
        end
        S_PWHI: begin
          y_r     <= pw_sum[65:32];
          n_r     <= n_r - 4'd1;
          state_r <= (n_r == 4'd1) ? S_RND : S_PWLO;
        end
        S_RND: begin
          e_r     <= 17'((y_r + 34'h8000) >> 16);
          state_r <= S_GAM;
        end
        S_GAM: begin
          wt_r    <= mul_p[24:0];
          state_r <= sel_r[0] ? S_DIAG : S_STORE;
        end
        S_DIAG: begin
          wt_r    <= mul_p[40:16];
          state_r <= S_STORE;
        end
        S_STORE: begin
          res_r[sel_r] <= wt_r[WT_W-1:0];
          if (sel_r == 2'd3) begin
            state_r <= S_OUT;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= S_NEXT;
          end
        end
        // hand the word to the output register
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            for (int i = 0; i < 4; i++) begin
              out_w_r[i] <= res_r[i];
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_weight    = out_w_r[0];
  assign out_upleft_weight  = out_w_r[1];
  assign out_up_weight      = out_w_r[2];
  assign out_upright_weight = out_w_r[3];

endmodule
